// ===== rtl/sha1_hash_engine_assert.svh =====
// Assertion macros for the SHA-1 hash engine.
// Used by the top level only; no other dependencies.
`ifndef SHA1_HASH_ENGINE_ASSERT_SVH
`define SHA1_HASH_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHA1_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sha1_pkg.sv =====
// Shared types, constants and helper functions of the SHA-1 hash engine.
// No dependencies; used by the controller, datapath, top level and testbench.
`default_nettype none

package sha1_pkg;

    typedef logic [31:0] t_word;

    localparam logic [5:0] BUF_LAST_POS  = 6'd63;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [6:0] ROUND_LAST    = 7'd79;
    localparam logic [6:0] ROUND_GRP1    = 7'd20;
    localparam logic [6:0] ROUND_GRP2    = 7'd40;
    localparam logic [6:0] ROUND_GRP3    = 7'd60;
    localparam logic [2:0] WORD_IDX_LAST = 3'd4;
    localparam logic [7:0] PAD_BYTE      = 8'h80;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } t_byte_src;

    typedef enum logic [1:0] {
        GRP_CH,
        GRP_PAR0,
        GRP_MAJ,
        GRP_PAR1
    } t_round_grp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       shift_en;
        t_byte_src  byte_src;
        logic       cnt_inc;
        logic       cnt_clr;
        logic       init_work;
        logic       round_en;
        t_round_grp grp;
        logic       chain_add;
        logic       chain_init;
        logic [2:0] word_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] pos;
    } t_dp_stat;

    function automatic t_word init_word(input logic [2:0] idx);
        t_word w;
        case (idx)
            3'd0:    w = 32'h67452301;
            3'd1:    w = 32'hefcdab89;
            3'd2:    w = 32'h98badcfe;
            3'd3:    w = 32'h10325476;
            default: w = 32'hc3d2e1f0;
        endcase
        return w;
    endfunction

    function automatic t_word round_k(input t_round_grp grp);
        t_word k;
        case (grp)
            GRP_CH:   k = 32'h5a827999;
            GRP_PAR0: k = 32'h6ed9eba1;
            GRP_MAJ:  k = 32'h8f1bbcdc;
            GRP_PAR1: k = 32'hca62c1d6;
            default:  k = 32'hca62c1d6;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sha1_if.sv =====
// Valid/ready stream interfaces for the message-byte input and the digest output.
// Depends on nothing but the language; the top level uses both.
`default_nettype none

interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       final_item;

    modport source (output valid, output data_byte, output has_byte, output final_item,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input final_item,
                  output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/sha1_dp.sv =====
// SHA-1 datapath: message schedule shift register, working variables, chaining
// value and byte counters. Depends on sha1_pkg; driven by sha1_ctrl commands.
`default_nettype none

module sha1_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]         i_data_byte,
    output sha1_pkg::t_dp_stat o_stat,
    output logic [31:0]        o_digest_word
);

    sha1_pkg::t_word r_w [16];
    sha1_pkg::t_word n_w [16];
    sha1_pkg::t_word r_a, r_b, r_c, r_d, r_e;
    sha1_pkg::t_word n_a, n_b, n_c, n_d, n_e;
    sha1_pkg::t_word r_h [5];
    sha1_pkg::t_word n_h [5];
    logic [63:0]     r_cnt, n_cnt;
    logic [5:0]      r_pos, n_pos;

    logic [63:0]     w_len_bits;
    logic [7:0]      w_len_byte;
    logic [7:0]      w_byte;
    sha1_pkg::t_word w_f;
    sha1_pkg::t_word w_t;
    sha1_pkg::t_word w_sched;

    // Length bytes go out most significant first while the buffer fills 56..63.
    assign w_len_bits = {r_cnt[60:0], 3'b000};
    assign w_len_byte = w_len_bits[{~r_pos[2:0], 3'b000} +: 8];

    always_comb begin
        case (i_cmd.byte_src)
            sha1_pkg::SRC_DATA: w_byte = i_data_byte;
            sha1_pkg::SRC_PAD:  w_byte = sha1_pkg::PAD_BYTE;
            sha1_pkg::SRC_ZERO: w_byte = 8'h00;
            sha1_pkg::SRC_LEN:  w_byte = w_len_byte;
            default:            w_byte = 8'h00;
        endcase
    end

    always_comb begin
        case (i_cmd.grp)
            sha1_pkg::GRP_CH:  w_f = (r_b & r_c) | (~r_b & r_d);
            sha1_pkg::GRP_MAJ: w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            default:           w_f = r_b ^ r_c ^ r_d;
        endcase
    end

    assign w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + sha1_pkg::round_k(i_cmd.grp) + r_w[0];

    // Word sixteen places ahead of the one consumed this round.
    always_comb begin
        sha1_pkg::t_word x;
        x = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_sched = {x[30:0], x[31]};
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_w[i] = r_w[i];
        end
        if (i_cmd.shift_en) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = {r_w[i][23:0], r_w[i + 1][31:24]};
            end
            n_w[15] = {r_w[15][23:0], w_byte};
        end else if (i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = r_w[i + 1];
            end
            n_w[15] = w_sched;
        end
    end

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_c = r_c;
        n_d = r_d;
        n_e = r_e;
        if (i_cmd.init_work) begin
            n_a = r_h[0];
            n_b = r_h[1];
            n_c = r_h[2];
            n_d = r_h[3];
            n_e = r_h[4];
        end else if (i_cmd.round_en) begin
            n_a = w_t;
            n_b = r_a;
            n_c = {r_b[1:0], r_b[31:2]};
            n_d = r_c;
            n_e = r_d;
        end
    end

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            n_h[i] = r_h[i];
        end
        if (i_cmd.chain_init) begin
            for (int i = 0; i < 5; i++) begin
                n_h[i] = sha1_pkg::init_word(3'(i));
            end
        end else if (i_cmd.chain_add) begin
            n_h[0] = r_h[0] + r_a;
            n_h[1] = r_h[1] + r_b;
            n_h[2] = r_h[2] + r_c;
            n_h[3] = r_h[3] + r_d;
            n_h[4] = r_h[4] + r_e;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + 64'd1;
        end
        n_pos = i_cmd.shift_en ? r_pos + 6'd1 : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= sha1_pkg::init_word(3'(i));
            end
            r_cnt <= '0;
            r_pos <= '0;
        end else begin
            r_h   <= n_h;
            r_cnt <= n_cnt;
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
        r_e <= n_e;
    end

    always_comb begin
        case (i_cmd.word_sel)
            3'd0:    o_digest_word = r_h[0];
            3'd1:    o_digest_word = r_h[1];
            3'd2:    o_digest_word = r_h[2];
            3'd3:    o_digest_word = r_h[3];
            3'd4:    o_digest_word = r_h[4];
            default: o_digest_word = r_h[4];
        endcase
    end

    assign o_stat.pos = r_pos;

endmodule

`default_nettype wire

// ===== rtl/sha1_ctrl.sv =====
// SHA-1 controller: sequences byte loading, padding, the 80 rounds and the
// digest output. Depends on sha1_pkg; drives sha1_dp through t_dp_cmd.
`default_nettype none

module sha1_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_has_byte,
    input  logic               i_final_item,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_word_index,
    output logic               o_last_word,
    input  sha1_pkg::t_dp_stat i_stat,
    output sha1_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    t_state     r_state;
    t_state     r_after;
    logic [6:0] r_round;
    logic [2:0] r_idx;

    logic w_full;
    logic w_accept;

    // The byte shifted in this cycle completes the block.
    assign w_full   = (i_stat.pos == sha1_pkg::BUF_LAST_POS);
    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = (r_state == ST_OUT);
    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == sha1_pkg::WORD_IDX_LAST);

    always_comb begin
        o_cmd          = '0;
        o_cmd.byte_src = sha1_pkg::SRC_DATA;
        o_cmd.word_sel = r_idx;
        if (r_round < sha1_pkg::ROUND_GRP1) begin
            o_cmd.grp = sha1_pkg::GRP_CH;
        end else if (r_round < sha1_pkg::ROUND_GRP2) begin
            o_cmd.grp = sha1_pkg::GRP_PAR0;
        end else if (r_round < sha1_pkg::ROUND_GRP3) begin
            o_cmd.grp = sha1_pkg::GRP_MAJ;
        end else begin
            o_cmd.grp = sha1_pkg::GRP_PAR1;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_has_byte) begin
                    o_cmd.shift_en  = 1'b1;
                    o_cmd.cnt_inc   = 1'b1;
                    o_cmd.init_work = w_full;
                end
            end
            ST_PAD: begin
                o_cmd.shift_en  = 1'b1;
                o_cmd.byte_src  = sha1_pkg::SRC_PAD;
                o_cmd.init_work = w_full;
            end
            ST_ZERO: begin
                if (i_stat.pos != sha1_pkg::LEN_POS) begin
                    o_cmd.shift_en  = 1'b1;
                    o_cmd.byte_src  = sha1_pkg::SRC_ZERO;
                    o_cmd.init_work = w_full;
                end
            end
            ST_LEN: begin
                o_cmd.shift_en  = 1'b1;
                o_cmd.byte_src  = sha1_pkg::SRC_LEN;
                o_cmd.init_work = w_full;
            end
            ST_ROUND: begin
                o_cmd.round_en = 1'b1;
            end
            ST_ADD: begin
                o_cmd.chain_add = 1'b1;
            end
            ST_OUT: begin
                if (i_out_ready && o_last_word) begin
                    o_cmd.chain_init = 1'b1;
                    o_cmd.cnt_clr    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_after <= ST_IDLE;
            r_round <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_has_byte && w_full) begin
                            r_state <= ST_ROUND;
                            r_round <= '0;
                            r_after <= i_final_item ? ST_PAD : ST_IDLE;
                        end else if (i_final_item) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_round <= '0;
                    r_after <= ST_ZERO;
                    r_state <= w_full ? ST_ROUND : ST_ZERO;
                end
                ST_ZERO: begin
                    r_round <= '0;
                    r_after <= ST_ZERO;
                    if (i_stat.pos == sha1_pkg::LEN_POS) begin
                        r_state <= ST_LEN;
                    end else if (w_full) begin
                        r_state <= ST_ROUND;
                    end
                end
                ST_LEN: begin
                    r_round <= '0;
                    r_idx   <= '0;
                    r_after <= ST_OUT;
                    if (w_full) begin
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_round <= r_round + 7'd1;
                    if (r_round == sha1_pkg::ROUND_LAST) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_state <= r_after;
                end
                ST_OUT: begin
                    if (i_out_ready) begin
                        if (o_last_word) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sha1_hash_engine.sv =====
// SHA-1 hash engine: takes at most one message byte per input item and, on a final
// item, pads the message and returns the 160-bit digest as five 32-bit result items,
// word 0 (most significant) first. Each full 64-byte block runs the 80
// rounds and the chaining add, during which no item is accepted. A final item
// then shifts in the pad, zero and length bytes up to the end of the last block
// (one or two blocks, each with its compression), pausing in ST_ZERO without a
// shift just before the length bytes, and the digest words go out as the sink
// takes them.
// After the last digest word the engine is back at the initial chaining value.
// Depends on sha1_pkg, sha1_if, sha1_ctrl, sha1_dp and the assertion header.
`default_nettype none

`include "sha1_hash_engine_assert.svh"

module sha1_hash_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha1_in_if.sink           i_in,
    sha1_out_if.source        o_out
);

    sha1_pkg::t_dp_cmd  w_cmd;
    sha1_pkg::t_dp_stat w_stat;

    sha1_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_has_byte   (i_in.has_byte),
        .i_final_item (i_in.final_item),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_word_index (o_out.word_index),
        .o_last_word  (o_out.last_word),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    sha1_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_byte   (i_in.data_byte),
        .o_stat        (w_stat),
        .o_digest_word (o_out.digest_word)
    );

    // The engine never takes an item while a digest word is pending.
    `SHA1_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, i_in.ready, !o_out.valid, "input ready while digest pending")

    // After the last digest word the engine is ready for a new message.
    `SHA1_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, o_out.valid && o_out.ready && o_out.last_word, i_in.ready && !o_out.valid, "not idle after last digest word")

    // Digest words come out back to back in index order.
    `SHA1_ASSERT_NEXT(a_word_order, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.last_word, o_out.valid && (o_out.word_index == $past(o_out.word_index) + 3'd1), "digest word out of order")

endmodule

`default_nettype wire

// ===== tb/tb_sha1_hash_engine.sv =====
// Self-checking testbench for sha1_hash_engine: streams messages byte by byte and
// checks every digest word against a SHA-1 model kept inside the bench.
// Depends on sha1_pkg, the stream interfaces in sha1_if.sv and the engine RTL.
`default_nettype none

module tb_sha1_hash_engine;

    localparam int unsigned  CYCLE_LIMIT = 200000;
    localparam int unsigned  DRAIN_WAIT  = 300;
    localparam logic [159:0] SHA1_IV     =
        160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;
    localparam sha1_pkg::t_word K_CH   = 32'h5a827999;
    localparam sha1_pkg::t_word K_PAR0 = 32'h6ed9eba1;
    localparam sha1_pkg::t_word K_MAJ  = 32'h8f1bbcdc;
    localparam sha1_pkg::t_word K_PAR1 = 32'hca62c1d6;

    typedef struct {
        logic [7:0]  data;
        logic        has_byte;
        logic        final_item;
        int unsigned gap;
        bit          drain_first;
    } t_feed_item;

    typedef struct {
        sha1_pkg::t_word digest_word;
        logic [2:0]      word_index;
        logic            last_word;
    } t_digest_res;

    logic i_clk;
    logic i_rst_n;

    sha1_in_if  in_if ();
    sha1_out_if out_if ();

    sha1_hash_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Model state of the engine.
    sha1_pkg::t_word hash_state [5];
    logic [7:0]      msg_block [64];
    logic [63:0]     msg_len;

    t_feed_item  pending_items [$];
    t_digest_res digest_q [$];
    t_feed_item  cur_item;

    bit          drv_busy;
    bit          in_took;
    bit          src_calm;
    bit          snk_calm;
    int unsigned gap_cnt;
    int unsigned stall_cnt;
    int unsigned cycle_cnt;
    int unsigned fail_cnt;
    int unsigned fed_items;
    int unsigned msg_cnt;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic void reset_hash();
        for (int i = 0; i < 5; i++) begin
            hash_state[i] = SHA1_IV[159 - 32 * i -: 32];
        end
        msg_len = '0;
    endfunction

    function automatic void fold_block();
        sha1_pkg::t_word w [16];
        sha1_pkg::t_word a, b, c, d, e, f, k, t, x;
        for (int r = 0; r < 16; r++) begin
            w[r] = {msg_block[4 * r], msg_block[4 * r + 1],
                    msg_block[4 * r + 2], msg_block[4 * r + 3]};
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < 80; r++) begin
            if (r >= 16) begin
                x = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
                w[r % 16] = {x[30:0], x[31]};
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_PAR0;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_PAR1;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // Takes one accepted item; on a final item pads the message and queues the digest.
    function automatic void sha1_absorb(input logic [7:0] b, input logic has, input logic fin);
        int          pos;
        logic [63:0] bits;
        t_digest_res res;
        if (has) begin
            msg_block[msg_len[5:0]] = b;
            msg_len++;
            if (msg_len[5:0] == 6'd0) fold_block();
        end
        if (!fin) return;
        pos = int'(msg_len[5:0]);
        bits = msg_len << 3;
        msg_block[pos] = sha1_pkg::PAD_BYTE;
        pos++;
        // No room left for the length field: it goes into an extra block.
        if (pos > sha1_pkg::LEN_POS) begin
            for (int i = pos; i < 64; i++) msg_block[i] = 8'h00;
            fold_block();
            pos = 0;
        end
        for (int i = pos; i < sha1_pkg::LEN_POS; i++) msg_block[i] = 8'h00;
        for (int i = 0; i < 8; i++) msg_block[sha1_pkg::LEN_POS + i] = bits[63 - 8 * i -: 8];
        fold_block();
        for (int i = 0; i < 5; i++) begin
            res.digest_word = hash_state[i];
            res.word_index  = 3'(i);
            res.last_word   = (3'(i) == sha1_pkg::WORD_IDX_LAST);
            digest_q.push_back(res);
        end
        reset_hash();
    endfunction

    function automatic void queue_item(input logic [7:0] d, input logic has, input logic fin,
                                       input bit drain);
        t_feed_item it;
        it.data        = d;
        it.has_byte    = has;
        it.final_item  = fin;
        it.gap         = src_calm ? 0 : $urandom_range(0, 11);
        it.drain_first = drain;
        pending_items.push_back(it);
        if (has || fin) fed_items++;
    endfunction

    function automatic void queue_message(input int len, input bit drain);
        bit fin_on_byte;
        fin_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) queue_item(8'($urandom), 1'b0, 1'b0, 1'b0);
            queue_item(8'($urandom), 1'b1, fin_on_byte && (i == len - 1), drain && (i == 0));
        end
        if (!fin_on_byte) queue_item(8'($urandom), 1'b0, 1'b1, drain && (len == 0));
        msg_cnt++;
    endfunction

    // Sender: presents queued items at the falling edge after their idle gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (drv_busy && in_took) drv_busy = 1'b0;
            in_took = 1'b0;
            if (!drv_busy && pending_items.size() != 0
                    && !(pending_items[0].drain_first && digest_q.size() != 0)) begin
                if (gap_cnt < pending_items[0].gap) begin
                    gap_cnt++;
                end else begin
                    cur_item = pending_items.pop_front();
                    drv_busy = 1'b1;
                    gap_cnt  = 0;
                end
            end
            in_if.valid      <= drv_busy;
            in_if.data_byte  <= cur_item.data;
            in_if.has_byte   <= cur_item.has_byte;
            in_if.final_item <= cur_item.final_item;
        end
    end

    // Receiver: holds ready low for a drawn number of cycles after each digest word.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_cnt != 0) begin
            out_if.ready <= 1'b0;
            stall_cnt--;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_digest_res want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (digest_q.size() == 0) begin
                    $error("digest word %h with no digest pending", out_if.digest_word);
                    fail_cnt++;
                end else begin
                    want = digest_q.pop_front();
                    if (out_if.digest_word !== want.digest_word) begin
                        $error("digest_word: expected %h, got %h",
                               want.digest_word, out_if.digest_word);
                        fail_cnt++;
                    end
                    if (out_if.word_index !== want.word_index) begin
                        $error("word_index: expected %0d, got %0d",
                               want.word_index, out_if.word_index);
                        fail_cnt++;
                    end
                    if (out_if.last_word !== want.last_word) begin
                        $error("last_word: expected %0b, got %0b",
                               want.last_word, out_if.last_word);
                        fail_cnt++;
                    end
                end
                if ($urandom_range(0, 7) == 0) snk_calm = !snk_calm;
                stall_cnt = snk_calm ? 0 : $urandom_range(0, 11);
            end
            if (in_if.valid && in_if.ready) begin
                sha1_absorb(in_if.data_byte, in_if.has_byte, in_if.final_item);
                in_took = 1'b1;
            end
        end
    end

    initial begin
        int lens [8];
        int len;
        lens = '{55, 56, 57, 63, 64, 65, 119, 120};
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = 8'h00;
        in_if.has_byte   = 1'b0;
        in_if.final_item = 1'b0;
        out_if.ready     = 1'b0;
        cur_item         = '{8'h00, 1'b0, 1'b0, 0, 1'b0};
        drv_busy         = 1'b0;
        in_took          = 1'b0;
        src_calm         = 1'b0;
        snk_calm         = 1'b0;
        gap_cnt          = 0;
        stall_cnt        = 3;
        cycle_cnt        = 0;
        fail_cnt         = 0;
        fed_items        = 0;
        msg_cnt          = 0;
        reset_hash();

        // Empty message, an ignored item, "abc", and single-byte messages at the extremes.
        queue_item(8'hA5, 1'b0, 1'b1, 1'b0);
        queue_item(8'h5A, 1'b0, 1'b0, 1'b0);
        queue_item(8'h61, 1'b1, 1'b0, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1, 1'b0);
        queue_item(8'hFF, 1'b1, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b0, 1'b1);
        queue_item(8'hFF, 1'b0, 1'b1, 1'b0);

        // Lengths around the padding boundaries dominate the long messages.
        while (fed_items < 330 || msg_cnt < 10) begin
            src_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(0, 12);
                5, 6, 7, 8:    len = lens[$urandom_range(0, 7)];
                default:       len = $urandom_range(13, 130);
            endcase
            queue_message(len, (msg_cnt == 2) || ($urandom_range(0, 5) == 0));
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_items.size() != 0 || drv_busy) @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sha1_hash_engine.f =====
+incdir+rtl
rtl/sha1_pkg.sv
rtl/sha1_if.sv
rtl/sha1_dp.sv
rtl/sha1_ctrl.sv
rtl/sha1_hash_engine.sv
tb/tb_sha1_hash_engine.sv
